// ----- src/mcsl_pkg.sv -----
// shared types, codes and constants for the motor command serial link
// no dependencies; imported by every other file of the block
package mcsl_pkg;

    localparam int PERIOD_W  = 16;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 3;
    localparam int SPEED_W   = 9;
    localparam int BITIDX_W  = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // request codes
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_SYNC  = 3'd1;
    localparam logic [OP_W-1:0] OP_SPEED = 3'd2;
    localparam logic [OP_W-1:0] OP_BRAKE = 3'd3;
    localparam logic [OP_W-1:0] OP_RECV  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_CODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_M0   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_M1   = 8'd3;

    localparam logic [PERIOD_W-1:0] RST_BIT_PERIOD = 16'd868;
    localparam logic [BYTE_W-1:0]   RST_SYNC_CODE  = 8'd170;
    localparam logic [BYTE_W-1:0]   RST_BRAKE_M0   = 8'd134;
    localparam logic [BYTE_W-1:0]   RST_BRAKE_M1   = 8'd135;

    localparam logic [BYTE_W-1:0] SPEED_BASE  = 8'h88;
    localparam logic [BYTE_W-1:0] DIR_FLAG    = 8'h02;
    localparam logic [BYTE_W-1:0] MOTOR1_FLAG = 8'h04;
    localparam logic [BYTE_W-1:0] VALUE_MAX   = 8'd127;

    localparam logic [BITIDX_W-1:0] BIT_STOP = 4'd8;
    localparam logic [BITIDX_W-1:0] BIT_DONE = 4'd9;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_TX   = 3'b010,
        PH_RX   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period;
        logic [BYTE_W-1:0]   sync_code;
        logic [BYTE_W-1:0]   brake_code_motor0;
        logic [BYTE_W-1:0]   brake_code_motor1;
    } t_cfg;

endpackage

// ----- src/mcsl_if.sv -----
// valid/ready channel interfaces: request, result and register write
// depends on mcsl_pkg for field widths
interface mcsl_req_if import mcsl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic                     motor;
    logic signed [SPEED_W-1:0] speed;
    logic [BYTE_W-1:0]        strength;
    logic                     rx_line;

    modport source (output valid, operation, motor, speed, strength, rx_line, input ready);
    modport sink   (input valid, operation, motor, speed, strength, rx_line, output ready);
endinterface

interface mcsl_res_if import mcsl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              tx_line;
    logic              busy_res;
    logic              accepted;
    logic [BYTE_W-1:0] rx_data;
    logic              rx_valid;

    modport source (output valid, tx_line, busy_res, accepted, rx_data, rx_valid, input ready);
    modport sink   (input valid, tx_line, busy_res, accepted, rx_data, rx_valid, output ready);
endinterface

interface mcsl_cfg_if import mcsl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/mcsl_cfg_regs.sv -----
// configuration register file, written through the register write channel
// depends on mcsl_pkg and mcsl_cfg_if
module mcsl_cfg_regs import mcsl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcsl_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BIT_PERIOD: n_cfg.bit_period        = i_cfg.data;
                REG_SYNC_CODE:  n_cfg.sync_code         = i_cfg.data[BYTE_W-1:0];
                REG_BRAKE_M0:   n_cfg.brake_code_motor0 = i_cfg.data[BYTE_W-1:0];
                REG_BRAKE_M1:   n_cfg.brake_code_motor1 = i_cfg.data[BYTE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_period        <= RST_BIT_PERIOD;
            r_cfg.sync_code         <= RST_SYNC_CODE;
            r_cfg.brake_code_motor0 <= RST_BRAKE_M0;
            r_cfg.brake_code_motor1 <= RST_BRAKE_M1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/mcsl_engine.sv -----
// per-tick link engine: tx/rx state, one step per request, registered result
// depends on mcsl_pkg and the channel interfaces
module mcsl_engine import mcsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    mcsl_req_if.sink    i_req,
    mcsl_res_if.source  o_res
);

    t_phase              r_phase,       n_phase;
    logic [PERIOD_W-1:0] r_tick_count,  n_tick_count;
    logic [BITIDX_W-1:0] r_bit_index,   n_bit_index;
    logic [BYTE_W-1:0]   r_tx_shift,    n_tx_shift;
    logic [BYTE_W-1:0]   r_second_byte, n_second_byte;
    logic                r_second_pend, n_second_pend;
    logic [BYTE_W-1:0]   r_rx_shift,    n_rx_shift;
    logic                r_line_level,  n_line_level;
    logic [BYTE_W-1:0]   r_rx_hold,     n_rx_hold;

    logic                r_out_valid;
    logic                r_accepted,    n_accepted;
    logic                r_rx_valid,    n_rx_valid;

    logic                in_fire;
    logic [PERIOD_W-1:0] period;
    logic                neg;
    logic [SPEED_W-1:0]  mag;
    logic [BYTE_W-1:0]   speed_val;
    logic [BYTE_W-1:0]   speed_cmd;
    logic [BYTE_W-1:0]   brake_val;

    // result register frees up when taken, so a request per cycle flows while results are taken
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign in_fire     = i_req.valid && i_req.ready;

    assign period = (i_cfg.bit_period == '0) ? PERIOD_W'(1) : i_cfg.bit_period;

    // magnitude in 9 bits; -256 gives 256 and saturates below
    assign neg       = i_req.speed[SPEED_W-1];
    assign mag       = neg ? (SPEED_W'(0) - SPEED_W'(i_req.speed)) : SPEED_W'(i_req.speed);
    assign speed_val = (mag > SPEED_W'(VALUE_MAX)) ? VALUE_MAX : mag[BYTE_W-1:0];
    // direction bit is inverted for motor 1
    assign speed_cmd = SPEED_BASE | (i_req.motor ? MOTOR1_FLAG : '0)
                     | ((neg ^ i_req.motor) ? DIR_FLAG : '0);
    assign brake_val = (i_req.strength > VALUE_MAX) ? VALUE_MAX : i_req.strength;

    always_comb begin
        n_phase       = r_phase;
        n_tick_count  = r_tick_count;
        n_bit_index   = r_bit_index;
        n_tx_shift    = r_tx_shift;
        n_second_byte = r_second_byte;
        n_second_pend = r_second_pend;
        n_rx_shift    = r_rx_shift;
        n_line_level  = r_line_level;
        n_rx_hold     = r_rx_hold;
        n_accepted    = 1'b0;
        n_rx_valid    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                case (i_req.operation)
                    OP_SYNC, OP_SPEED, OP_BRAKE: begin
                        n_accepted   = 1'b1;
                        n_phase      = PH_TX;
                        n_bit_index  = '0;
                        n_tick_count = PERIOD_W'(1);
                        n_line_level = 1'b0;
                        if (i_req.operation == OP_SYNC) begin
                            n_second_pend = 1'b0;
                            n_tx_shift    = i_cfg.sync_code;
                        end else if (i_req.operation == OP_SPEED) begin
                            n_second_pend = 1'b1;
                            n_second_byte = speed_val;
                            n_tx_shift    = speed_cmd;
                        end else begin
                            n_second_pend = 1'b1;
                            n_second_byte = brake_val;
                            n_tx_shift    = i_req.motor ? i_cfg.brake_code_motor1
                                                        : i_cfg.brake_code_motor0;
                        end
                    end
                    OP_RECV: begin
                        n_accepted   = 1'b1;
                        n_phase      = PH_RX;
                        n_rx_shift   = '0;
                        n_bit_index  = '0;
                        n_tick_count = PERIOD_W'(1);
                    end
                    default: n_accepted = 1'b0;
                endcase
            end
            PH_TX: begin
                if (r_tick_count < period) begin
                    n_tick_count = r_tick_count + PERIOD_W'(1);
                end else begin
                    n_tick_count = PERIOD_W'(1);
                    if (r_bit_index < BIT_STOP) begin
                        n_line_level = r_tx_shift[0];
                        n_tx_shift   = r_tx_shift >> 1;
                        n_bit_index  = r_bit_index + BITIDX_W'(1);
                    end else if (r_bit_index == BIT_STOP) begin
                        n_line_level = 1'b1;
                        n_bit_index  = BIT_DONE;
                    end else if (r_second_pend) begin
                        // value byte follows the command byte at once
                        n_second_pend = 1'b0;
                        n_tx_shift    = r_second_byte;
                        n_bit_index   = '0;
                        n_line_level  = 1'b0;
                    end else begin
                        n_phase      = PH_IDLE;
                        n_line_level = 1'b1;
                        n_bit_index  = '0;
                        n_tick_count = '0;
                    end
                end
            end
            PH_RX: begin
                if (r_tick_count < period) begin
                    n_tick_count = r_tick_count + PERIOD_W'(1);
                end else begin
                    n_tick_count = PERIOD_W'(1);
                    if (r_bit_index < BIT_STOP) begin
                        // shift first, then the new sample lands in bit 7
                        n_rx_shift  = {i_req.rx_line, r_rx_shift[BYTE_W-1:1]};
                        n_bit_index = r_bit_index + BITIDX_W'(1);
                        if (r_bit_index == BIT_STOP - BITIDX_W'(1)) begin
                            n_rx_hold  = n_rx_shift;
                            n_rx_valid = 1'b1;
                        end
                    end else if (r_bit_index == BIT_STOP) begin
                        n_bit_index = BIT_DONE;
                    end else begin
                        n_phase      = PH_IDLE;
                        n_bit_index  = '0;
                        n_tick_count = '0;
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick_count  <= '0;
            r_bit_index   <= '0;
            r_tx_shift    <= '0;
            r_second_byte <= '0;
            r_second_pend <= 1'b0;
            r_rx_shift    <= '0;
            r_line_level  <= 1'b1;
            r_rx_hold     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase       <= n_phase;
                r_tick_count  <= n_tick_count;
                r_bit_index   <= n_bit_index;
                r_tx_shift    <= n_tx_shift;
                r_second_byte <= n_second_byte;
                r_second_pend <= n_second_pend;
                r_rx_shift    <= n_rx_shift;
                r_line_level  <= n_line_level;
                r_rx_hold     <= n_rx_hold;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_accepted <= n_accepted;
            r_rx_valid <= n_rx_valid;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.tx_line  = r_line_level;
    assign o_res.busy_res = (r_phase != PH_IDLE);
    assign o_res.accepted = r_accepted;
    assign o_res.rx_data  = r_rx_hold;
    assign o_res.rx_valid = r_rx_valid;

`ifndef SYNTHESIS
    a_busy_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_phase != PH_IDLE) |=> !r_accepted)
        else $error("request taken while link busy");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted request produced no result");
    a_idle_counters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> (r_bit_index == '0 && r_tick_count == '0 && r_line_level))
        else $error("idle with counters running or line low");
    a_rx_valid_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rx_valid) |-> (r_phase == PH_RX && r_bit_index == BIT_STOP))
        else $error("byte completion outside reception");
    a_bit_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= BIT_DONE)
        else $error("bit index past stop bit");
`endif

endmodule

// ----- src/motor_command_serial_link_top.sv -----
// Motor command serial link: 8N1 transmitter/receiver stepped once per request.
// An accepted request's result is in the output register in the cycle after acceptance.
// Throughput: one request per cycle while results are taken; the result register decouples the two sides.
// Bit timing advances only on accepted requests (each request is one tick).
// Reset (i_rst_n low, synchronous): link idle, line high, registers to defaults.
module motor_command_serial_link_top import mcsl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcsl_req_if.sink    i_req,
    mcsl_res_if.source  o_res,
    mcsl_cfg_if.sink    i_cfg
);

    t_cfg cfg;

    mcsl_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mcsl_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (i_req),
        .o_res   (o_res)
    );

endmodule

// ----- tb/sv/motor_command_serial_link_top_test.sv -----
`timescale 1ns / 1ps
// self-checking testbench for motor_command_serial_link_top: a line-level predictor
// runs in step with every accepted request; depends on mcsl_pkg, mcsl_if and the block
module motor_command_serial_link_top_test;
    import mcsl_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [OP_W-1:0]      OP_LAST_CODE = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 8'd4;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic                      motor;
        logic signed [SPEED_W-1:0] speed;
        logic [BYTE_W-1:0]         strength;
        logic                      rx_line;
    } t_link_req;

    typedef struct packed {
        logic              tx_line;
        logic              busy_res;
        logic              accepted;
        logic [BYTE_W-1:0] rx_data;
        logic              rx_valid;
    } t_link_out;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mcsl_req_if req_ch ();
    mcsl_res_if res_ch ();
    mcsl_cfg_if cfg_ch ();

    motor_command_serial_link_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // predicted link state and registers
    t_cfg                link_cfg;
    t_phase              lk_phase;
    logic [PERIOD_W-1:0] lk_ticks;
    logic [BITIDX_W-1:0] lk_bit;
    logic [BYTE_W-1:0]   lk_tx_shift;
    logic [BYTE_W-1:0]   lk_second;
    logic [BYTE_W-1:0]   lk_rx_shift;
    logic [BYTE_W-1:0]   lk_rx_hold;
    logic                lk_second_pending;
    logic                lk_line;

    t_link_out link_states_due[$];
    int        fail_count    = 0;
    int        burst_left    = 0;
    bit        steady_sender = 1'b0;
    bit        hold_off_req  = 1'b0;
    int        hold_count    = 0;
    logic [7:0] stall_phase  = '0;

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    function automatic void load_frame(input logic [BYTE_W-1:0] value);
        lk_phase    = PH_TX;
        lk_tx_shift = value;
        lk_bit      = '0;
        lk_ticks    = PERIOD_W'(1);
        lk_line     = 1'b0;
    endfunction

    // one clock tick of the link; returns the line state after the tick
    function automatic t_link_out advance_link(input t_link_req r);
        t_link_out           o;
        logic [PERIOD_W-1:0] period;
        logic [SPEED_W-1:0]  speed_raw;
        logic [SPEED_W-1:0]  speed_mag;
        logic [BYTE_W-1:0]   cmd;
        logic                reverse;
        o = '0;
        if (lk_phase == PH_IDLE) begin
            case (r.operation)
                OP_SYNC: begin
                    o.accepted        = 1'b1;
                    lk_second_pending = 1'b0;
                    load_frame(link_cfg.sync_code);
                end
                OP_SPEED: begin
                    speed_raw = r.speed;
                    reverse   = speed_raw[SPEED_W-1];
                    speed_mag = reverse ? -speed_raw : speed_raw;
                    if (speed_mag > VALUE_MAX) speed_mag = SPEED_W'(VALUE_MAX);
                    cmd = SPEED_BASE;
                    // motor 1 turns the other way round
                    if (r.motor) begin
                        cmd     = cmd | MOTOR1_FLAG;
                        reverse = ~reverse;
                    end
                    if (reverse) cmd = cmd | DIR_FLAG;
                    o.accepted        = 1'b1;
                    lk_second         = speed_mag[BYTE_W-1:0];
                    lk_second_pending = 1'b1;
                    load_frame(cmd);
                end
                OP_BRAKE: begin
                    o.accepted        = 1'b1;
                    lk_second         = (r.strength > VALUE_MAX) ? VALUE_MAX : r.strength;
                    lk_second_pending = 1'b1;
                    load_frame(r.motor ? link_cfg.brake_code_motor1
                                       : link_cfg.brake_code_motor0);
                end
                OP_RECV: begin
                    o.accepted  = 1'b1;
                    lk_phase    = PH_RX;
                    lk_rx_shift = '0;
                    lk_bit      = '0;
                    lk_ticks    = PERIOD_W'(1);
                end
                default: ;
            endcase
        end else begin
            period = link_cfg.bit_period;
            if (period == '0) period = PERIOD_W'(1);
            if (lk_ticks < period) begin
                lk_ticks = lk_ticks + PERIOD_W'(1);
            end else if (lk_phase == PH_TX) begin
                lk_ticks = PERIOD_W'(1);
                if (lk_bit < BIT_STOP) begin
                    lk_line     = lk_tx_shift[0];
                    lk_tx_shift = lk_tx_shift >> 1;
                    lk_bit      = lk_bit + BITIDX_W'(1);
                end else if (lk_bit == BIT_STOP) begin
                    lk_line = 1'b1;
                    lk_bit  = BIT_DONE;
                end else if (lk_second_pending) begin
                    lk_second_pending = 1'b0;
                    load_frame(lk_second);
                end else begin
                    lk_phase = PH_IDLE;
                    lk_line  = 1'b1;
                    lk_bit   = '0;
                    lk_ticks = '0;
                end
            end else begin
                lk_ticks = PERIOD_W'(1);
                if (lk_bit < BIT_STOP) begin
                    // shift first, then the new bit lands in bit 7
                    lk_rx_shift = {r.rx_line, lk_rx_shift[BYTE_W-1:1]};
                    lk_bit      = lk_bit + BITIDX_W'(1);
                    if (lk_bit == BIT_STOP) begin
                        lk_rx_hold = lk_rx_shift;
                        o.rx_valid = 1'b1;
                    end
                end else if (lk_bit == BIT_STOP) begin
                    lk_bit = BIT_DONE;
                end else begin
                    lk_phase = PH_IDLE;
                    lk_bit   = '0;
                    lk_ticks = '0;
                end
            end
        end
        o.tx_line  = lk_line;
        o.busy_res = (lk_phase != PH_IDLE);
        o.rx_data  = lk_rx_hold;
        return o;
    endfunction

    function automatic t_link_req cmd_req(input logic [OP_W-1:0] op, input logic motor,
                                          input int speed_val, input int strength_val);
        t_link_req r;
        r.operation = op;
        r.motor     = motor;
        r.speed     = speed_val[SPEED_W-1:0];
        r.strength  = strength_val[BYTE_W-1:0];
        r.rx_line   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // sender: bursts of random length with random gaps in between
    task automatic send_request(input t_link_req r);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!steady_sender && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.operation <= r.operation;
        req_ch.motor     <= r.motor;
        req_ch.speed     <= r.speed;
        req_ch.strength  <= r.strength;
        req_ch.rx_line   <= r.rx_line;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        link_states_due.push_back(advance_link(r));
        burst_left--;
    endtask

    task automatic tick_until_idle(input bit rx_random, input logic rx_level);
        t_link_req r;
        while (lk_phase != PH_IDLE) begin
            r = cmd_req(OP_NONE, 1'b0, 0, 0);
            if (!rx_random) r.rx_line = rx_level;
            send_request(r);
        end
    endtask

    task automatic run_command(input logic [OP_W-1:0] op, input logic motor,
                               input int speed_val, input int strength_val);
        send_request(cmd_req(op, motor, speed_val, strength_val));
        tick_until_idle(1'b1, 1'b0);
    endtask

    task automatic drain_link();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (link_states_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            REG_BIT_PERIOD: link_cfg.bit_period        = value;
            REG_SYNC_CODE:  link_cfg.sync_code         = value[BYTE_W-1:0];
            REG_BRAKE_M0:   link_cfg.brake_code_motor0 = value[BYTE_W-1:0];
            REG_BRAKE_M1:   link_cfg.brake_code_motor1 = value[BYTE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n_items);
        t_link_req r;
        repeat (n_items) begin
            r = cmd_req(OP_NONE, 1'($urandom_range(0, 1)), $urandom, $urandom);
            if (lk_phase == PH_IDLE)
                r.operation = ($urandom_range(0, 9) == 0)
                            ? OP_W'($urandom_range(OP_NONE, OP_LAST_CODE))
                            : OP_W'($urandom_range(OP_SYNC, OP_RECV));
            else if ($urandom_range(0, 7) == 0)
                r.operation = OP_W'($urandom_range(OP_NONE, OP_LAST_CODE));
            send_request(r);
        end
    endtask

    // default registers; the period is cut short in the middle of the sync frame
    task automatic test_reset_values();
        send_request(cmd_req(OP_SYNC, 1'b0, 0, 0));
        repeat (20) send_request(cmd_req(OP_NONE, 1'b0, 0, 0));
        drain_link();
        write_register(REG_BIT_PERIOD, 16'd1);
        tick_until_idle(1'b1, 1'b0);
        run_command(OP_BRAKE, 1'b0, 0, 128);
        run_command(OP_BRAKE, 1'b1, 0, 127);
    endtask

    task automatic test_speed_commands();
        int speeds[8] = '{0, 127, 128, 255, -1, -128, -255, -256};
        drain_link();
        write_register(REG_BIT_PERIOD, 16'd1);
        for (int i = 0; i < 8; i++) run_command(OP_SPEED, i[0], speeds[i], 0);
    endtask

    task automatic test_receive();
        drain_link();
        write_register(REG_BIT_PERIOD, 16'd2);
        send_request(cmd_req(OP_RECV, 1'b0, 0, 0));
        tick_until_idle(1'b0, 1'b1);
        send_request(cmd_req(OP_RECV, 1'b1, 0, 0));
        tick_until_idle(1'b0, 1'b0);
        run_command(OP_RECV, 1'b0, 0, 0);
    endtask

    // unknown codes, and requests made while the link is busy
    task automatic test_ignored_requests();
        for (int code = OP_RECV + 1; code <= OP_LAST_CODE; code++)
            send_request(cmd_req(code[OP_W-1:0], 1'b1, -5, 200));
        send_request(cmd_req(OP_SYNC, 1'b0, 0, 0));
        send_request(cmd_req(OP_SPEED, 1'b1, -50, 0));
        send_request(cmd_req(OP_BRAKE, 1'b0, 0, 99));
        send_request(cmd_req(OP_RECV, 1'b0, 0, 0));
        tick_until_idle(1'b1, 1'b0);
    endtask

    task automatic test_register_extremes();
        drain_link();
        write_register(REG_SYNC_CODE, 16'h0000);
        write_register(REG_BIT_PERIOD, 16'd0);
        run_command(OP_SYNC, 1'b0, 0, 0);
        drain_link();
        write_register(REG_SYNC_CODE, 16'hFFFF);
        write_register(REG_BRAKE_M0, 16'hFF00);
        write_register(REG_BRAKE_M1, 16'h00FF);
        write_register(REG_UNUSED, 16'hA5A5);
        run_command(OP_SYNC, 1'b1, 0, 0);
        run_command(OP_BRAKE, 1'b0, 0, 255);
        run_command(OP_BRAKE, 1'b1, 0, 0);
        drain_link();
        write_register(REG_BIT_PERIOD, 16'hFFFF);
        send_request(cmd_req(OP_SYNC, 1'b0, 0, 0));
        repeat (20) send_request(cmd_req(OP_NONE, 1'b0, 0, 0));
        drain_link();
        write_register(REG_BIT_PERIOD, 16'd1);
        tick_until_idle(1'b1, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        steady_sender = 1'b1;
        hold_off_req  = 1'b1;
        random_traffic(40);
        steady_sender = 1'b0;
        tick_until_idle(1'b1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int periods[5] = '{1, 2, 0, 3, 4};
        for (int p = 0; p < 5; p++) begin
            drain_link();
            write_register(REG_BIT_PERIOD, CFG_DAT_W'(periods[p]));
            write_register(REG_SYNC_CODE, CFG_DAT_W'($urandom));
            write_register(REG_BRAKE_M0, CFG_DAT_W'($urandom));
            write_register(REG_BRAKE_M1, CFG_DAT_W'($urandom));
            random_traffic(20);
        end
    endtask

    // result stall pattern of its own, overridden by a long hold-off on demand
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            res_ch.ready <= 1'b0;
            hold_count++;
            if (hold_count == HOLD_CYCLES) begin
                hold_count   = 0;
                hold_off_req = 1'b0;
            end
        end else begin
            stall_phase <= stall_phase + 8'd1;
            case (stall_phase[7:6])
                2'd0:    res_ch.ready <= 1'b1;
                2'd1:    res_ch.ready <= (stall_phase[1:0] != 2'd3);
                2'd2:    res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_link_out due;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (link_states_due.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                due = link_states_due.pop_front();
                if (res_ch.tx_line !== due.tx_line) begin
                    $error("tx_line: expected %0d, got %0d", due.tx_line, res_ch.tx_line);
                    fail_count++;
                end
                if (res_ch.busy_res !== due.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", due.busy_res, res_ch.busy_res);
                    fail_count++;
                end
                if (res_ch.accepted !== due.accepted) begin
                    $error("accepted: expected %0d, got %0d", due.accepted, res_ch.accepted);
                    fail_count++;
                end
                if (res_ch.rx_data !== due.rx_data) begin
                    $error("rx_data: expected 0x%02h, got 0x%02h", due.rx_data, res_ch.rx_data);
                    fail_count++;
                end
                if (res_ch.rx_valid !== due.rx_valid) begin
                    $error("rx_valid: expected %0d, got %0d", due.rx_valid, res_ch.rx_valid);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : test_sequence
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_NONE;
        req_ch.motor     = 1'b0;
        req_ch.speed     = '0;
        req_ch.strength  = '0;
        req_ch.rx_line   = 1'b1;
        res_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_BIT_PERIOD;
        cfg_ch.data      = '0;

        link_cfg          = '{RST_BIT_PERIOD, RST_SYNC_CODE, RST_BRAKE_M0, RST_BRAKE_M1};
        lk_phase          = PH_IDLE;
        lk_ticks          = '0;
        lk_bit            = '0;
        lk_tx_shift       = '0;
        lk_second         = '0;
        lk_second_pending = 1'b0;
        lk_rx_shift       = '0;
        lk_rx_hold        = '0;
        lk_line           = 1'b1;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_speed_commands();
        test_receive();
        test_ignored_requests();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();

        drain_link();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/mcsl_pkg.sv
src/mcsl_if.sv
src/mcsl_cfg_regs.sv
src/mcsl_engine.sv
src/motor_command_serial_link_top.sv
tb/sv/motor_command_serial_link_top_test.sv
